[rtl/core/ssmb_pkg.sv]
// ----------------------------------------------------------------------------
// ssmb_pkg: shared definitions for the saturating stereo mix buffer
// Widths, register indexes, request kinds and the command word that travels
// from the front end through the queue to the buffer back end.
// ----------------------------------------------------------------------------
package ssmb_pkg;

  localparam int DEF_BUFFER_FRAMES = 4096;
  localparam int QUEUE_DEPTH       = 4;
  localparam int INDEX_W           = 12;
  localparam int SAMPLE_W          = 16;
  localparam int VOLUME_W          = 16;
  localparam int FIU_W             = 13;
  localparam int GAIN_W            = 2 * VOLUME_W;
  localparam int PROD_W            = SAMPLE_W + GAIN_W;
  localparam int FRAC_W            = 24;

  localparam logic [VOLUME_W-1:0] MASTER_VOLUME_RST = 16'd4096;
  localparam logic [FIU_W-1:0]    FRAMES_IN_USE_RST = 13'd4096;

  localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_LO = -16'sd32767;

  typedef enum logic {
    KIND_MIX  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic {
    REG_MASTER_VOLUME = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } reg_idx_t;

  // Classified request handed to the buffer back end
  typedef struct packed {
    kind_t                      kind;
    logic [INDEX_W-1:0]         idx;
    logic                       in_range;
    logic signed [SAMPLE_W-1:0] add_left;
    logic signed [SAMPLE_W-1:0] add_right;
  } cmd_t;

endpackage

[rtl/core/ssmb_front.sv]
// ----------------------------------------------------------------------------
// ssmb_front: request intake and sample scaling
// Accepts requests, checks the frame index, drops out-of-range mixes and
// scales source samples by volume times master volume in two stages.
// ----------------------------------------------------------------------------
module ssmb_front #(
  parameter int BUFFER_FRAMES = ssmb_pkg::DEF_BUFFER_FRAMES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept_en,
  input  logic [ssmb_pkg::VOLUME_W-1:0]         master_volume,
  input  logic [ssmb_pkg::FIU_W-1:0]            frames_in_use,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [ssmb_pkg::INDEX_W-1:0]          in_frame_index,
  input  logic signed [ssmb_pkg::SAMPLE_W-1:0]  in_sample_left,
  input  logic signed [ssmb_pkg::SAMPLE_W-1:0]  in_sample_right,
  input  logic                                  in_stereo,
  input  logic [ssmb_pkg::VOLUME_W-1:0]         in_volume,
  output logic                                  cmd_valid,
  input  logic                                  cmd_ready,
  output ssmb_pkg::cmd_t                        cmd
);
  import ssmb_pkg::*;

  localparam logic [INDEX_W+4:0] FRAME_LIM = (INDEX_W+5)'(BUFFER_FRAMES);
  localparam int HI_W = PROD_W - FRAC_W;

  // Fold a product's integer part into a clamped signed sample
  function automatic logic signed [SAMPLE_W-1:0] fold(input logic [HI_W-1:0] hi,
                                                      input logic neg);
    logic [SAMPLE_W-2:0] m;
    logic signed [SAMPLE_W-1:0] v;
    begin
      m = (|hi[HI_W-1:SAMPLE_W-1]) ? SAT_HI[SAMPLE_W-2:0] : hi[SAMPLE_W-2:0];
      v = $signed({1'b0, m});
      return neg ? -v : v;
    end
  endfunction

  // stage 1: request plus combined gain
  logic                       s1_v_r, s1_v_nxt;
  kind_t                      s1_kind_r;
  logic [INDEX_W-1:0]         s1_idx_r;
  logic                       s1_inr_r;
  logic                       s1_stereo_r;
  logic signed [SAMPLE_W-1:0] s1_sl_r, s1_sr_r;
  logic [GAIN_W-1:0]          s1_gain_r;

  // stage 2: request plus scaled magnitudes
  logic                       s2_v_r, s2_v_nxt;
  kind_t                      s2_kind_r;
  logic [INDEX_W-1:0]         s2_idx_r;
  logic                       s2_inr_r;
  logic                       s2_stereo_r;
  logic                       s2_neg_l_r, s2_neg_r_r;
  logic [HI_W-1:0]            s2_hi_l_r, s2_hi_r_r;

  logic                       s1_ready, s2_ready, accept, in_rng, keep;
  logic [SAMPLE_W-1:0]        mag_l, mag_r;
  logic [PROD_W-1:0]          prod_l, prod_r;
  logic signed [SAMPLE_W-1:0] scl_l, scl_r;

  // Advance stages whenever the next one has room
  assign s2_ready = !s2_v_r || cmd_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready && accept_en;
  assign accept   = in_valid && in_ready;

  // Classify: index must be below both the session size and the buffer size
  assign in_rng = ({1'b0, in_frame_index} < frames_in_use) &&
                  ({5'b0, in_frame_index} < FRAME_LIM);
  assign keep   = (kind_t'(in_kind) == KIND_READ) || in_rng;

  assign s1_v_nxt = s1_ready ? (accept && keep) : s1_v_r;
  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Capture request and form the Q8.24 gain
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_idx_r    <= in_frame_index;
      s1_inr_r    <= in_rng;
      s1_stereo_r <= in_stereo;
      s1_sl_r     <= in_sample_left;
      s1_sr_r     <= in_sample_right;
      s1_gain_r   <= GAIN_W'(in_volume) * GAIN_W'(master_volume);
    end
  end

  // Scale magnitudes; keep only the integer part of each product
  assign mag_l  = s1_sl_r[SAMPLE_W-1] ? SAMPLE_W'(-s1_sl_r) : SAMPLE_W'(s1_sl_r);
  assign mag_r  = s1_sr_r[SAMPLE_W-1] ? SAMPLE_W'(-s1_sr_r) : SAMPLE_W'(s1_sr_r);
  assign prod_l = PROD_W'(mag_l) * PROD_W'(s1_gain_r);
  assign prod_r = PROD_W'(mag_r) * PROD_W'(s1_gain_r);

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_kind_r   <= s1_kind_r;
      s2_idx_r    <= s1_idx_r;
      s2_inr_r    <= s1_inr_r;
      s2_stereo_r <= s1_stereo_r;
      s2_neg_l_r  <= s1_sl_r[SAMPLE_W-1];
      s2_neg_r_r  <= s1_sr_r[SAMPLE_W-1];
      s2_hi_l_r   <= prod_l[PROD_W-1:FRAC_W];
      s2_hi_r_r   <= prod_r[PROD_W-1:FRAC_W];
    end
  end

  // Clamp, restore sign, duplicate mono
  assign scl_l = fold(s2_hi_l_r, s2_neg_l_r);
  assign scl_r = s2_stereo_r ? fold(s2_hi_r_r, s2_neg_r_r) : scl_l;

  always_comb begin
    cmd.kind      = s2_kind_r;
    cmd.idx       = s2_idx_r;
    cmd.in_range  = s2_inr_r;
    cmd.add_left  = scl_l;
    cmd.add_right = scl_r;
  end

  assign cmd_valid = s2_v_r;

endmodule

[rtl/core/ssmb_queue.sv]
// ----------------------------------------------------------------------------
// ssmb_queue: short request queue
// Decouples the scaling front end from the buffer back end so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module ssmb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ssmb_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ssmb_pkg::cmd_t pop_cmd
);
  import ssmb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = q_mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/ssmb_back.sv]
// ----------------------------------------------------------------------------
// ssmb_back: frame buffer read-modify-write engine
// Clears the buffer after reset, then reads the addressed frame, adds the
// scaled samples with saturation or returns and clears the frame.
// ----------------------------------------------------------------------------
module ssmb_back #(
  parameter int BUFFER_FRAMES = ssmb_pkg::DEF_BUFFER_FRAMES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  output logic                                  init_done,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  ssmb_pkg::cmd_t                        cmd,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ssmb_pkg::SAMPLE_W-1:0]  out_mixed_left,
  output logic signed [ssmb_pkg::SAMPLE_W-1:0]  out_mixed_right,
  output logic                                  out_in_range
);
  import ssmb_pkg::*;

  localparam int AW = $clog2(BUFFER_FRAMES);
  localparam int DW = 2 * SAMPLE_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_FRAMES - 1);

  // Saturating add of two samples to +/-32767
  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] s;
    begin
      s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (s > $signed({SAT_HI[SAMPLE_W-1], SAT_HI})) begin
        return SAT_HI;
      end else if (s < $signed({SAT_LO[SAMPLE_W-1], SAT_LO})) begin
        return SAT_LO;
      end
      return s[SAMPLE_W-1:0];
    end
  endfunction

  // Map the 12-bit frame index onto the buffer address width
  function automatic logic [AW-1:0] to_addr(input logic [INDEX_W-1:0] idx);
    logic [AW+INDEX_W-1:0] t;
    begin
      t = {{AW{1'b0}}, idx};
      return t[AW-1:0];
    end
  endfunction

  logic [DW-1:0]  mem [BUFFER_FRAMES];

  logic           init_done_r;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;

  logic           b1_v_r, b1_v_nxt;
  cmd_t           b1_cmd_r;
  logic [DW-1:0]  rd_data_r;

  logic           lw_v_r;
  logic [AW-1:0]  lw_addr_r;
  logic [DW-1:0]  lw_data_r;

  logic           out_valid_r, out_valid_nxt;
  logic           out_inr_r;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r;

  logic           b1_adv, b1_free, pop, b1_is_read, upd;
  logic [AW-1:0]  b1_addr;
  logic [DW-1:0]  stored, upd_data;
  logic signed [SAMPLE_W-1:0] st_l, st_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;

  // Accept from the queue only when the buffer is cleared and stage 1 is empty or moves
  assign b1_is_read = (b1_cmd_r.kind == KIND_READ);
  assign b1_adv     = b1_v_r && (!b1_is_read || !out_valid_r || out_ready);
  assign b1_free    = !b1_v_r || b1_adv;
  assign cmd_ready  = init_done_r && b1_free;
  assign pop        = cmd_valid && cmd_ready;
  assign b1_v_nxt   = b1_free ? pop : b1_v_r;
  assign init_done  = init_done_r;

  // Forward the last write when it targets the same frame
  assign b1_addr = to_addr(b1_cmd_r.idx);
  assign stored  = (lw_v_r && lw_addr_r == b1_addr) ? lw_data_r : rd_data_r;
  assign st_l    = stored[DW-1:SAMPLE_W];
  assign st_r    = stored[SAMPLE_W-1:0];

  // Mix adds with saturation, read clears the frame
  assign upd      = b1_adv && b1_cmd_r.in_range;
  assign upd_data = b1_is_read ? '0 :
                    {sat_add(st_l, b1_cmd_r.add_left), sat_add(st_r, b1_cmd_r.add_right)};

  // Share the write port between the clearing sweep and updates
  always_comb begin
    if (!init_done_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = upd;
      mem_waddr = b1_addr;
      mem_wdata = upd_data;
    end
  end

  assign clr_addr_nxt = init_done_r ? clr_addr_r : clr_addr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      if (!init_done_r && clr_addr_r == LAST_ADDR) begin
        init_done_r <= 1'b1;
      end
    end
  end

  // Frame buffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[to_addr(cmd.idx)];
    end
  end

  // Stage 1 control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      lw_v_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
      if (upd) begin
        lw_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_cmd_r <= cmd;
    end
    if (upd) begin
      lw_addr_r <= b1_addr;
      lw_data_r <= upd_data;
    end
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b1_adv && b1_is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv && b1_is_read) begin
      out_inr_r <= b1_cmd_r.in_range;
      out_l_r   <= b1_cmd_r.in_range ? st_l : '0;
      out_r_r   <= b1_cmd_r.in_range ? st_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mixed_left  = out_l_r;
  assign out_mixed_right = out_r_r;
  assign out_in_range    = out_inr_r;

  // No request leaves the queue during the clearing sweep
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done_r |-> !pop)
    else $error("request popped during buffer clear");

  // A completed read shows up in the output register next cycle
  a_read_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_adv && b1_is_read) |=> out_valid_r)
    else $error("read result lost");

  // Stored samples never reach -32768
  a_no_min_sample: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wdata[DW-1:SAMPLE_W] != 16'h8000 &&
                mem_wdata[SAMPLE_W-1:0] != 16'h8000))
    else $error("stored sample out of clamp range");

  // Out-of-range reads return silence
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inr_r) |-> (out_l_r == '0 && out_r_r == '0))
    else $error("out-of-range read returned data");

endmodule

[rtl/core/saturating_stereo_mix_buffer_top.sv]
// ----------------------------------------------------------------------------
// saturating_stereo_mix_buffer_top: stereo mix accumulation buffer
// Mixes scaled source frames into a saturating stereo buffer and returns
// and clears frames on read; gains and session size set over APB.
// ----------------------------------------------------------------------------
// Throughput is one request per clock, sustained, while results are taken:
// the buffer memory does one read and one write each cycle, and a one-deep
// write forward covers back-to-back requests to the same frame. A request
// passes two scaling stages, a four-entry queue and a read-modify-write
// stage before a read result is presented in the output register. After
// reset the buffer's BUFFER_FRAMES frames (4096 by default) are swept to
// zero; in_ready stays low until the sweep ends, while APB writes are
// taken at any time. Mix requests return nothing; each read returns one
// result, zeros with out_in_range low when the index is outside the session.
module saturating_stereo_mix_buffer_top #(
  parameter int BUFFER_FRAMES = ssmb_pkg::DEF_BUFFER_FRAMES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [ssmb_pkg::INDEX_W-1:0]          in_frame_index,
  input  logic signed [ssmb_pkg::SAMPLE_W-1:0]  in_sample_left,
  input  logic signed [ssmb_pkg::SAMPLE_W-1:0]  in_sample_right,
  input  logic                                  in_stereo,
  input  logic [ssmb_pkg::VOLUME_W-1:0]         in_volume,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ssmb_pkg::SAMPLE_W-1:0]  out_mixed_left,
  output logic signed [ssmb_pkg::SAMPLE_W-1:0]  out_mixed_right,
  output logic                                  out_in_range
);
  import ssmb_pkg::*;

  logic [VOLUME_W-1:0] master_volume_r;
  logic [FIU_W-1:0]    frames_in_use_r;
  reg_idx_t            reg_sel;
  logic                cfg_wr;
  logic                init_done;
  logic                fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t                fq_cmd, qb_cmd;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_volume_r <= MASTER_VOLUME_RST;
      frames_in_use_r <= FRAMES_IN_USE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MASTER_VOLUME: master_volume_r <= pwdata[VOLUME_W-1:0];
        REG_FRAMES_IN_USE: frames_in_use_r <= pwdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MASTER_VOLUME: prdata = 32'(master_volume_r);
      REG_FRAMES_IN_USE: prdata = 32'(frames_in_use_r);
      default:           prdata = '0;
    endcase
  end

  ssmb_front #(
    .BUFFER_FRAMES (BUFFER_FRAMES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept_en       (init_done),
    .master_volume   (master_volume_r),
    .frames_in_use   (frames_in_use_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_frame_index  (in_frame_index),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_stereo       (in_stereo),
    .in_volume       (in_volume),
    .cmd_valid       (fq_valid),
    .cmd_ready       (fq_ready),
    .cmd             (fq_cmd)
  );

  ssmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  ssmb_back #(
    .BUFFER_FRAMES (BUFFER_FRAMES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .init_done       (init_done),
    .cmd_valid       (qb_valid),
    .cmd_ready       (qb_ready),
    .cmd             (qb_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mixed_left  (out_mixed_left),
    .out_mixed_right (out_mixed_right),
    .out_in_range    (out_in_range)
  );

endmodule
